@@ hdl/ccs_pkg.sv @@
// Shared types, microcode table and constants for the cocktail shaker sorter.
package ccs_pkg;

  localparam int DATA_W = 32;
  localparam int PC_W   = 4;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_INTAKE,
    OP_SETUP,
    OP_ROUND,
    OP_FLOAD,
    OP_FREAD,
    OP_FCMP,
    OP_FEND,
    OP_BLOAD,
    OP_BREAD,
    OP_BCMP,
    OP_BEND,
    OP_EINIT,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  // Branch condition; when taken the step counter loads the target.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_HOLD,
    C_NO_ROUND,
    C_FWD_MORE,
    C_NO_BACK,
    C_BWD_MORE,
    C_EMIT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Status flags from the datapath, sampled by the branch logic.
  typedef struct packed {
    logic close;       // closing transaction accepted
    logic round_open;  // lower bound still below upper bound
    logic fwd_more;    // forward pass has another compare
    logic back_none;   // backward pass would be empty
    logic bwd_more;    // backward pass has another compare
    logic emit_done;   // final element loaded into the output register
  } stat_t;

  localparam logic [PC_W-1:0] ST_INTAKE = 4'd0;
  localparam logic [PC_W-1:0] ST_SETUP  = 4'd1;
  localparam logic [PC_W-1:0] ST_ROUND  = 4'd2;
  localparam logic [PC_W-1:0] ST_FLOAD  = 4'd3;
  localparam logic [PC_W-1:0] ST_FREAD  = 4'd4;
  localparam logic [PC_W-1:0] ST_FCMP   = 4'd5;
  localparam logic [PC_W-1:0] ST_FEND   = 4'd6;
  localparam logic [PC_W-1:0] ST_BLOAD  = 4'd7;
  localparam logic [PC_W-1:0] ST_BREAD  = 4'd8;
  localparam logic [PC_W-1:0] ST_BCMP   = 4'd9;
  localparam logic [PC_W-1:0] ST_BEND   = 4'd10;
  localparam logic [PC_W-1:0] ST_EINIT  = 4'd11;
  localparam logic [PC_W-1:0] ST_EMIT   = 4'd12;
  localparam logic [PC_W-1:0] ST_CLEAR  = 4'd13;

  // Microprogram ROM: one control word per step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{OP_CLEAR, C_ALWAYS, ST_INTAKE};
    case (pc)
      ST_INTAKE: w = '{OP_INTAKE, C_HOLD,      ST_INTAKE};
      ST_SETUP:  w = '{OP_SETUP,  C_NEXT,      ST_INTAKE};
      ST_ROUND:  w = '{OP_ROUND,  C_NO_ROUND,  ST_EINIT};
      ST_FLOAD:  w = '{OP_FLOAD,  C_NEXT,      ST_INTAKE};
      ST_FREAD:  w = '{OP_FREAD,  C_NEXT,      ST_INTAKE};
      ST_FCMP:   w = '{OP_FCMP,   C_FWD_MORE,  ST_FREAD};
      ST_FEND:   w = '{OP_FEND,   C_NO_BACK,   ST_EINIT};
      ST_BLOAD:  w = '{OP_BLOAD,  C_NEXT,      ST_INTAKE};
      ST_BREAD:  w = '{OP_BREAD,  C_NEXT,      ST_INTAKE};
      ST_BCMP:   w = '{OP_BCMP,   C_BWD_MORE,  ST_BREAD};
      ST_BEND:   w = '{OP_BEND,   C_ALWAYS,    ST_ROUND};
      ST_EINIT:  w = '{OP_EINIT,  C_NEXT,      ST_INTAKE};
      ST_EMIT:   w = '{OP_EMIT,   C_EMIT_BUSY, ST_EMIT};
      ST_CLEAR:  w = '{OP_CLEAR,  C_ALWAYS,    ST_INTAKE};
      default:   w = '{OP_CLEAR,  C_ALWAYS,    ST_INTAKE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/cocktail_shaker_sorter.sv @@
// Top level of the cocktail shaker sorter: microcode sequencer plus datapath.
//
// Collects signed 32-bit values, one per input transaction, into a DEPTH-entry
// RAM; the transaction with in_last high closes the set. Values that arrive
// while DEPTH elements are held are dropped, and every result of that set then
// carries out_overflowed. The set is sorted ascending in place by alternating
// forward and backward bubble passes and streamed out smallest first, with
// out_final_res on the last one. For n held elements the sort has a setup step,
// then each compare-exchange takes a RAM read step and a compare and write-back
// step through the single read port, plus the control steps ROUND, FLOAD, FEND,
// BLOAD and BEND in each of up to n/2 rounds (the last may skip the backward
// ones). Emission then loads the elements in order into the output register,
// waiting while it holds an untaken result, and a clear step returns the block
// to intake. No new set is accepted until the previous one has been fully
// handed to the output register; the output register lets the last result wait
// while intake of the next set already runs.
module cocktail_shaker_sorter #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  input  logic               in_valid,
  output logic               in_ready,
  output logic signed [31:0] out_sorted_value,
  output logic               out_final_res,
  output logic               out_overflowed,
  output logic               out_valid,
  input  logic               out_ready
);
  import ccs_pkg::*;

  op_t   op;   // control word operation from the sequencer
  stat_t stat; // branch flags back from the datapath

  // Step counter and control ROM.
  ccs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // Element RAM, sort registers and output register.
  ccs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .in_value         (in_value),
    .in_last          (in_last),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflowed   (out_overflowed),
    .out_valid        (out_valid),
    .out_ready        (out_ready)
  );

endmodule

@@ hdl/ccs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ccs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ccs_useq.sv @@
// Microcode sequencer: step counter, control ROM and branch evaluation.
module ccs_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  ccs_pkg::stat_t stat,
  output ccs_pkg::op_t   op
);
  import ccs_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uword_t          uw;
  logic            taken;

  assign uw = ucode(pc_r);
  assign op = uw.op;

  always_comb begin
    case (uw.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_HOLD:      taken = !stat.close;
      C_NO_ROUND:  taken = !stat.round_open;
      C_FWD_MORE:  taken = stat.fwd_more;
      C_NO_BACK:   taken = stat.back_none;
      C_BWD_MORE:  taken = stat.bwd_more;
      C_EMIT_BUSY: taken = !stat.emit_done;
      default:     taken = 1'b1;
    endcase
    pc_nxt = taken ? uw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_INTAKE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // A closing transaction must start the sort on the next step.
  a_close_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_INTAKE && stat.close) |=> (uw.op == OP_SETUP))
    else $error("close did not start the sort");

endmodule

@@ hdl/ccs_dpath.sv @@
// Datapath: element RAM, bounds and index registers, carry register and output register.
module ccs_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ccs_pkg::op_t              op,
  output ccs_pkg::stat_t            stat,
  input  logic signed [31:0]        in_value,
  input  logic                      in_last,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic signed [31:0]        out_sorted_value,
  output logic                      out_final_res,
  output logic                      out_overflowed,
  output logic                      out_valid,
  input  logic                      out_ready
);
  import ccs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [DATA_W-1:0] carry_r, carry_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              accept;
  logic              out_free;
  logic              last_el;
  logic              fwd_swap;
  logic              bwd_swap;
  logic [AW-1:0]     j_inc;
  logic [AW-1:0]     j_dec;
  logic [AW-1:0]     lo_inc;

  ccs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (op == OP_INTAKE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last_el  = ((CW'(j_r) + CW'(1)) == cnt_r);
  assign j_inc    = j_r + 1'b1;
  assign j_dec    = j_r - 1'b1;
  assign lo_inc   = lo_r + 1'b1;
  // Forward: carried max moves on past a smaller neighbor.
  assign fwd_swap = $signed(carry_r) > $signed(ram_rdata);
  // Backward: carried min moves on past a larger neighbor.
  assign bwd_swap = $signed(carry_r) < $signed(ram_rdata);

  assign stat.close      = accept && in_last;
  assign stat.round_open = (lo_r < hi_r);
  assign stat.fwd_more   = (j_inc < hi_r);
  assign stat.back_none  = (hi_r <= lo_inc);
  assign stat.bwd_more   = (j_r > lo_inc);
  assign stat.emit_done  = out_free && last_el;

  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = j_r;
    ram_wdata     = carry_r;
    ram_raddr     = j_r;
    case (op)
      OP_INTAKE: begin
        if (accept) begin
          if (cnt_r < CW'(DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cnt_r);
            ram_wdata = in_value;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_SETUP: begin
        lo_nxt = '0;
        hi_nxt = AW'(cnt_r - 1'b1);
      end
      OP_ROUND: begin
        ram_raddr = lo_r;
        j_nxt     = lo_r;
      end
      OP_FLOAD: begin
        carry_nxt = ram_rdata;
      end
      OP_FREAD: begin
        ram_raddr = j_inc;
      end
      OP_FCMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = fwd_swap ? ram_rdata : carry_r;
        carry_nxt = fwd_swap ? carry_r : ram_rdata;
        j_nxt     = j_inc;
      end
      OP_FEND: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = carry_r;
        hi_nxt    = hi_r - 1'b1;
        j_nxt     = hi_r - 1'b1;
        ram_raddr = hi_r - 1'b1;
      end
      OP_BLOAD: begin
        carry_nxt = ram_rdata;
      end
      OP_BREAD: begin
        ram_raddr = j_dec;
      end
      OP_BCMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = bwd_swap ? ram_rdata : carry_r;
        carry_nxt = bwd_swap ? carry_r : ram_rdata;
        j_nxt     = j_dec;
      end
      OP_BEND: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = carry_r;
        lo_nxt    = lo_inc;
      end
      OP_EINIT: begin
        j_nxt     = '0;
        ram_raddr = '0;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = ram_rdata;
          out_final_nxt = last_el;
          out_ovf_nxt   = ovf_r;
          j_nxt         = j_inc;
        end
        // Keep the read address one ahead of the register it feeds.
        ram_raddr = j_nxt;
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r         <= j_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    carry_r     <= carry_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_res    = out_final_r;
  assign out_overflowed   = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above buffer depth");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |-> (CW'(j_r) < cnt_r))
    else $error("emit index beyond stored elements");

  a_final_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT && stat.emit_done) |=> (out_valid_r && out_final_r))
    else $error("last element not presented as final");

endmodule
